@@ rtl/grid_reachability_flood_fill_core_macros.svh @@
// Assertion macros used by the checker of the flood fill core.
// Depends on nothing; included by the checker module.
`ifndef GRID_REACHABILITY_FLOOD_FILL_CORE_MACROS_SVH
`define GRID_REACHABILITY_FLOOD_FILL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRFC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grfc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GRFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grfc assertion failed");

`endif

@@ rtl/grfc_pkg.sv @@
// Shared types and codes of the grid flood fill core.
// Used by the core and by its checker; depends on nothing.
package grfc_pkg;

  localparam int STAMP_W = 16;
  localparam int CFG_W   = 7;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Neighbor directions in the order they are tried.
  typedef enum logic [1:0] {
    DIR_E = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_N = 2'd3
  } dir_t;

endpackage

@@ rtl/grfc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module grfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/grid_reachability_flood_fill_core.sv @@
// Top level of the grid flood fill core: cell store, walk stack and control.
// Depends on grfc_pkg and grfc_ram.
//
// The core keeps an open/blocked bit and a 16-bit visit stamp per cell in one
// memory and the pending cells of the walk in a second memory. A write
// transaction reads the cell, then writes it back with the stamp kept; a
// write outside the store is dropped in its accept cycle. A query walks the
// grid by popping cells from the stack; the single read port of the cell
// memory tests one neighbor per cycle. The 65536th query and every 65535th
// query after it first run a pass that clears every stamp. After reset the
// core clears the cell memory and accepts no transaction until it is done;
// configuration writes are taken at all times.
module grid_reachability_flood_fill_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_addr,
  input  logic [grfc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  input  logic [5:0] x,
  input  logic [5:0] y,
  input  logic cell_open,
  input  logic [5:0] goal_x,
  input  logic [5:0] goal_y,
  output logic out_valid,
  input  logic out_ready,
  output logic reachable
);
  import grfc_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = CW + RW;
  localparam int MW    = STAMP_W + 1;
  localparam int CMAX  = (CW > RW) ? CW : RW;
  localparam int CMPW  = ((CMAX > CFG_W) ? CMAX : CFG_W) + 1;
  localparam logic [CFG_W-1:0] COL_CAP = CFG_W'((MAX_COLS < 127) ? MAX_COLS : 127);
  localparam logic [CFG_W-1:0] ROW_CAP = CFG_W'((MAX_ROWS < 127) ? MAX_ROWS : 127);
  localparam logic [AW-1:0]    ROWS_A  = AW'(MAX_ROWS);
  localparam logic [AW:0]      CELLS_C = (AW+1)'(CELLS);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_WR_RD, ST_WR_WB, ST_WRAP, ST_Q_ENTER,
    ST_S_WB, ST_POP, ST_POP_WAIT, ST_CHK, ST_FIN
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                              input logic [RW-1:0] cy);
    return AW'(cx) * ROWS_A + AW'(cy);
  endfunction

  state_t             state;
  logic [AW:0]        sw;
  logic [AW:0]        depth;
  logic [STAMP_W-1:0] epoch;
  logic [CFG_W-1:0]   width_reg, height_reg;
  logic [5:0]         sx, sy, gx, gy;
  logic               wopn;
  logic [CW-1:0]      cur_x, pend_x;
  logic [RW-1:0]      cur_y, pend_y;
  logic               pend_ok;
  dir_t               k;
  logic               res;

  logic [CFG_W-1:0]   cols_lim, rows_lim;
  logic [CMPW-1:0]    w_c, h_c, sx_c, sy_c;
  logic [STAMP_W-1:0] epoch_inc;
  logic               start_in, store_in, goal_hit, hit;
  logic [CW-1:0]      base_x, nb_x, stk_x;
  logic [RW-1:0]      base_y, nb_y, stk_y;
  logic [CMPW-1:0]    bx, by, nbx_w, nby_w;
  dir_t               dir_sel;
  logic               nb_ok;
  logic [AW-1:0]      start_addr;

  logic               map_we, stk_we;
  logic [AW-1:0]      map_waddr, map_raddr, stk_waddr, stk_raddr;
  logic [MW-1:0]      map_wdata, map_rdata;
  logic [SW-1:0]      stk_wdata, stk_rdata;

  grfc_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  grfc_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Out-of-range sizes act as 1 or as the store dimension.
  always_comb begin
    cols_lim = (width_reg == '0) ? CFG_W'(1) :
               (width_reg > COL_CAP) ? COL_CAP : width_reg;
    rows_lim = (height_reg == '0) ? CFG_W'(1) :
               (height_reg > ROW_CAP) ? ROW_CAP : height_reg;
    w_c = CMPW'(cols_lim);
    h_c = CMPW'(rows_lim);
    sx_c = CMPW'(sx);
    sy_c = CMPW'(sy);
    start_in = (sx_c < w_c) && (sy_c < h_c);
    store_in = (CMPW'(x) < CMPW'(MAX_COLS)) && (CMPW'(y) < CMPW'(MAX_ROWS));
    start_addr = cell_addr(sx_c[CW-1:0], sy_c[RW-1:0]);
    epoch_inc = epoch + STAMP_W'(1);
    stk_x = stk_rdata[SW-1:RW];
    stk_y = stk_rdata[RW-1:0];
    goal_hit = (CMPW'(stk_x) == CMPW'(gx)) && (CMPW'(stk_y) == CMPW'(gy));
    hit = pend_ok && map_rdata[MW-1] && (map_rdata[STAMP_W-1:0] != epoch);
  end

  // Neighbor of the popped cell (straight from the stack) or of the current one.
  always_comb begin
    base_x  = (state == ST_POP_WAIT) ? stk_x : cur_x;
    base_y  = (state == ST_POP_WAIT) ? stk_y : cur_y;
    dir_sel = (state == ST_POP_WAIT) ? DIR_E : dir_t'(k + 2'd1);
    bx = CMPW'(base_x);
    by = CMPW'(base_y);
    nbx_w = bx;
    nby_w = by;
    nb_ok = 1'b0;
    case (dir_sel)
      DIR_E: begin
        nbx_w = bx + CMPW'(1);
        nb_ok = nbx_w < w_c;
      end
      DIR_S: begin
        nby_w = by + CMPW'(1);
        nb_ok = nby_w < h_c;
      end
      DIR_W: begin
        nbx_w = bx - CMPW'(1);
        nb_ok = bx != '0;
      end
      DIR_N: begin
        nby_w = by - CMPW'(1);
        nb_ok = by != '0;
      end
      default: nb_ok = 1'b0;
    endcase
    nb_x = nbx_w[CW-1:0];
    nb_y = nby_w[RW-1:0];
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = start_addr;
    map_wdata = {map_rdata[MW-1], epoch};
    map_raddr = start_addr;
    stk_we    = 1'b0;
    stk_waddr = depth[AW-1:0];
    stk_wdata = {pend_x, pend_y};
    stk_raddr = AW'(depth - (AW+1)'(1));
    case (state)
      ST_CLR: begin
        map_we    = 1'b1;
        map_waddr = sw[AW-1:0];
        map_wdata = '0;
      end
      ST_WR_WB: begin
        map_we    = 1'b1;
        map_wdata = {wopn, map_rdata[STAMP_W-1:0]};
      end
      ST_WRAP: begin
        // Read one entry ahead and write back the previous one with its stamp cleared.
        map_raddr = sw[AW-1:0];
        map_we    = sw != '0;
        map_waddr = AW'(sw - (AW+1)'(1));
        map_wdata = {map_rdata[MW-1], {STAMP_W{1'b0}}};
      end
      ST_S_WB: begin
        map_we    = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {sx_c[CW-1:0], sy_c[RW-1:0]};
      end
      ST_POP_WAIT: begin
        map_raddr = cell_addr(nb_x, nb_y);
      end
      ST_CHK: begin
        map_we    = hit;
        map_waddr = cell_addr(pend_x, pend_y);
        map_wdata = {1'b1, epoch};
        stk_we    = hit;
        map_raddr = cell_addr(nb_x, nb_y);
      end
      default: map_we = 1'b0;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      sw         <= '0;
      depth      <= '0;
      epoch      <= '0;
      width_reg  <= CFG_W'(64);
      height_reg <= CFG_W'(64);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          CFG_WIDTH:  width_reg  <= cfg_wdata;
          CFG_HEIGHT: height_reg <= cfg_wdata;
          default:    width_reg  <= width_reg;
        endcase
      end
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          sw <= sw + (AW+1)'(1);
          if (sw == CELLS_C - (AW+1)'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            sx   <= x;
            sy   <= y;
            gx   <= goal_x;
            gy   <= goal_y;
            wopn <= cell_open;
            if (action_t'(action) == ACT_QUERY) begin
              if (epoch_inc == '0) begin
                epoch <= STAMP_W'(1);
                sw    <= '0;
                state <= ST_WRAP;
              end else begin
                epoch <= epoch_inc;
                state <= ST_Q_ENTER;
              end
            end else if (store_in) begin
              state <= ST_WR_RD;
            end
          end
        end
        ST_WR_RD: state <= ST_WR_WB;
        ST_WR_WB: state <= ST_IDLE;
        ST_WRAP: begin
          sw <= sw + (AW+1)'(1);
          if (sw == CELLS_C) begin
            state <= ST_Q_ENTER;
          end
        end
        ST_Q_ENTER: begin
          if (!start_in) begin
            res   <= (sx == gx) && (sy == gy);
            state <= ST_FIN;
          end else begin
            state <= ST_S_WB;
          end
        end
        ST_S_WB: begin
          depth <= (AW+1)'(1);
          state <= ST_POP;
        end
        ST_POP: begin
          if (depth == '0) begin
            res   <= 1'b0;
            state <= ST_FIN;
          end else begin
            depth <= depth - (AW+1)'(1);
            state <= ST_POP_WAIT;
          end
        end
        ST_POP_WAIT: begin
          cur_x <= stk_x;
          cur_y <= stk_y;
          if (goal_hit) begin
            res   <= 1'b1;
            state <= ST_FIN;
          end else begin
            pend_ok <= nb_ok;
            pend_x  <= nb_x;
            pend_y  <= nb_y;
            k       <= DIR_E;
            state   <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (hit) begin
            depth <= depth + (AW+1)'(1);
          end
          pend_ok <= nb_ok;
          pend_x  <= nb_x;
          pend_y  <= nb_y;
          k       <= dir_sel;
          if (k == DIR_N) begin
            state <= ST_POP;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            reachable <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/grfc_checker.sv @@
// Port-level checks of the grid flood fill core, bound to its top level.
// Depends on grfc_pkg and the assertion macro header.
`include "grid_reachability_flood_fill_core_macros.svh"

module grfc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic action,
  input logic out_valid,
  input logic out_ready,
  input logic reachable
);
  import grfc_pkg::*;

  // A result that waits keeps its value.
  `GRFC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(reachable))

  // A query transaction occupies the core for at least the following cycle.
  `GRFC_ASSERT_NEXT(a_query_busy, clk, rst, in_valid && in_ready && action == ACT_QUERY, !in_ready)

  // Reset leaves no result pending.
  `GRFC_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !out_valid)

  // The core does not take new work while clearing right after reset.
  `GRFC_ASSERT_NEXT(a_rst_busy, clk, 1'b0, rst, !in_ready)

endmodule

bind grid_reachability_flood_fill_core grfc_checker u_grfc_checker (.*);
